>>> rtl/core/assert_macros.svh
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, checked on every rising edge outside reset
`define ASSERT_IMPLIES(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, checked on every rising edge outside reset
`define ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

>>> rtl/core/rfdc_pkg.sv
package rfdc_pkg;

  // field widths
  localparam int CMD_W   = 3;
  localparam int TYPE_W  = 4;
  localparam int ID_W    = 32;
  localparam int IDX_W   = 6;
  localparam int PEND_W  = 7;
  localparam int DROP_W  = 32;
  localparam int ENTRY_W = TYPE_W + ID_W;
  localparam int ADDR_W  = 3;
  localparam int DATA_W  = 32;

  // command codes
  localparam logic [CMD_W-1:0] CMD_PUSH  = 3'd0;
  localparam logic [CMD_W-1:0] CMD_POP   = 3'd1;
  localparam logic [CMD_W-1:0] CMD_CHECK = 3'd2;
  localparam logic [CMD_W-1:0] CMD_PEEK  = 3'd3;
  localparam logic [CMD_W-1:0] CMD_CLEAR = 3'd4;

  // register map
  localparam logic [ADDR_W-1:0] ADDR_INVALID_ID = 3'd0;

  localparam logic [DROP_W-1:0] DROP_MAX = '1;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_EXEC,
    ST_SCAN
  } state_t;

  // which queue offset the entry memory reads next
  typedef enum logic [1:0] {
    RD_HEAD,
    RD_IDX,
    RD_SCAN
  } rd_sel_t;

  typedef enum logic [2:0] {
    OP_NONE,
    OP_PUSH,
    OP_POP,
    OP_PEEK,
    OP_CLEAR,
    OP_REJECT,
    OP_CHECK_END,
    OP_SCAN_ADV
  } dp_op_t;

  typedef struct packed {
    logic    latch;
    rd_sel_t rd_sel;
    dp_op_t  op;
    logic    check_ok;
  } dp_cmd_t;

  typedef struct packed {
    logic [CMD_W-1:0] cmd;
    logic             id_invalid;
    logic             empty;
    logic             hit;
    logic             last;
  } dp_stat_t;

endpackage

>>> rtl/core/request_fifo_with_drop_count_core.sv
// push, pop, peek, clear and unknown commands: start latches the command, the EXEC
// state registers the result strobe, next command accepted in the strobe cycle, busy before it
// check: one queued entry compared per cycle through the single memory read
// port, from the head until a hit or the last entry, busy until the strobe
// synchronous reset empties the queue, zeroes the drop counter and invalid_id;
// entry memory is not cleared, the receiver cannot stall
module request_fifo_with_drop_count_core #(
  parameter int DEPTH = 64
) (
  input  logic                          clk,
  input  logic                          rst,
  // command side
  input  logic                          start,
  output logic                          busy,
  input  logic [rfdc_pkg::CMD_W-1:0]    command,
  input  logic [rfdc_pkg::TYPE_W-1:0]   req_type,
  input  logic [rfdc_pkg::ID_W-1:0]     asset_id,
  input  logic [rfdc_pkg::IDX_W-1:0]    entry_index,
  // result side, one word per done strobe
  output logic                          done,
  output logic                          ok,
  output logic [rfdc_pkg::TYPE_W-1:0]   out_type,
  output logic [rfdc_pkg::ID_W-1:0]     out_id,
  output logic [rfdc_pkg::PEND_W-1:0]   pending_count,
  output logic [rfdc_pkg::DROP_W-1:0]   dropped_total,
  output logic                          first_drop,
  // register port
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [rfdc_pkg::ADDR_W-1:0]   paddr,
  input  logic [rfdc_pkg::DATA_W-1:0]   pwdata,
  output logic [rfdc_pkg::DATA_W-1:0]   prdata,
  output logic                          pready
);

  rfdc_pkg::dp_cmd_t  dp_cmd;
  rfdc_pkg::dp_stat_t dp_stat;

  logic [rfdc_pkg::ID_W-1:0] invalid_id;
  logic                      reg_hit;
  logic                      reg_we;

  // single register: invalid_id at byte address 0, other addresses read zero
  assign reg_hit = (paddr == rfdc_pkg::ADDR_INVALID_ID);
  assign reg_we  = psel && penable && pwrite && reg_hit;
  assign pready  = 1'b1;
  assign prdata  = reg_hit ? invalid_id : '0;

  always_ff @(posedge clk) begin
    if (rst) begin
      invalid_id <= '0;
    end else if (reg_we) begin
      invalid_id <= pwdata;
    end
  end

  // sequencer: accept, execute, optional scan of the queue
  rfdc_ctrl u_ctrl (
    .clk     (clk),
    .rst     (rst),
    .start   (start),
    .command (command),
    .stat    (dp_stat),
    .cmd     (dp_cmd),
    .busy    (busy)
  );

  // ring buffer, pointers, drop counter and result word
  rfdc_dp #(
    .DEPTH (DEPTH)
  ) u_dp (
    .clk           (clk),
    .rst           (rst),
    .cmd           (dp_cmd),
    .stat          (dp_stat),
    .command       (command),
    .req_type      (req_type),
    .asset_id      (asset_id),
    .entry_index   (entry_index),
    .invalid_id    (invalid_id),
    .done          (done),
    .ok            (ok),
    .out_type      (out_type),
    .out_id        (out_id),
    .pending_count (pending_count),
    .dropped_total (dropped_total),
    .first_drop    (first_drop)
  );

endmodule

>>> rtl/core/rfdc_ctrl.sv
module rfdc_ctrl (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       start,
  input  logic [rfdc_pkg::CMD_W-1:0] command,
  input  rfdc_pkg::dp_stat_t         stat,
  output rfdc_pkg::dp_cmd_t          cmd,
  output logic                       busy
);

  rfdc_pkg::state_t state;
  rfdc_pkg::state_t state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= rfdc_pkg::ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next   = state;
    cmd.latch    = 1'b0;
    cmd.rd_sel   = rfdc_pkg::RD_HEAD;
    cmd.op       = rfdc_pkg::OP_NONE;
    cmd.check_ok = 1'b0;
    busy         = 1'b1;
    case (state)
      rfdc_pkg::ST_IDLE: begin
        busy = 1'b0;
        // pop and check want the head, peek its own offset
        if (command == rfdc_pkg::CMD_PEEK) begin
          cmd.rd_sel = rfdc_pkg::RD_IDX;
        end
        if (start) begin
          cmd.latch  = 1'b1;
          state_next = rfdc_pkg::ST_EXEC;
        end
      end
      rfdc_pkg::ST_EXEC: begin
        state_next = rfdc_pkg::ST_IDLE;
        case (stat.cmd)
          rfdc_pkg::CMD_PUSH:  cmd.op = rfdc_pkg::OP_PUSH;
          rfdc_pkg::CMD_POP:   cmd.op = rfdc_pkg::OP_POP;
          rfdc_pkg::CMD_PEEK:  cmd.op = rfdc_pkg::OP_PEEK;
          rfdc_pkg::CMD_CLEAR: cmd.op = rfdc_pkg::OP_CLEAR;
          rfdc_pkg::CMD_CHECK: begin
            if (stat.id_invalid || stat.empty) begin
              cmd.op = rfdc_pkg::OP_CHECK_END;
            end else if (stat.hit) begin
              cmd.op       = rfdc_pkg::OP_CHECK_END;
              cmd.check_ok = 1'b1;
            end else if (stat.last) begin
              cmd.op = rfdc_pkg::OP_CHECK_END;
            end else begin
              cmd.op     = rfdc_pkg::OP_SCAN_ADV;
              cmd.rd_sel = rfdc_pkg::RD_SCAN;
              state_next = rfdc_pkg::ST_SCAN;
            end
          end
          default: cmd.op = rfdc_pkg::OP_REJECT;
        endcase
      end
      rfdc_pkg::ST_SCAN: begin
        cmd.rd_sel = rfdc_pkg::RD_SCAN;
        if (stat.hit) begin
          cmd.op       = rfdc_pkg::OP_CHECK_END;
          cmd.check_ok = 1'b1;
          state_next   = rfdc_pkg::ST_IDLE;
        end else if (stat.last) begin
          cmd.op     = rfdc_pkg::OP_CHECK_END;
          state_next = rfdc_pkg::ST_IDLE;
        end else begin
          cmd.op = rfdc_pkg::OP_SCAN_ADV;
        end
      end
      default: state_next = rfdc_pkg::ST_IDLE;
    endcase
  end

endmodule

>>> rtl/core/rfdc_dp.sv
module rfdc_dp #(
  parameter int DEPTH = 64
) (
  input  logic                        clk,
  input  logic                        rst,
  input  rfdc_pkg::dp_cmd_t           cmd,
  output rfdc_pkg::dp_stat_t          stat,
  input  logic [rfdc_pkg::CMD_W-1:0]  command,
  input  logic [rfdc_pkg::TYPE_W-1:0] req_type,
  input  logic [rfdc_pkg::ID_W-1:0]   asset_id,
  input  logic [rfdc_pkg::IDX_W-1:0]  entry_index,
  input  logic [rfdc_pkg::ID_W-1:0]   invalid_id,
  output logic                        done,
  output logic                        ok,
  output logic [rfdc_pkg::TYPE_W-1:0] out_type,
  output logic [rfdc_pkg::ID_W-1:0]   out_id,
  output logic [rfdc_pkg::PEND_W-1:0] pending_count,
  output logic [rfdc_pkg::DROP_W-1:0] dropped_total,
  output logic                        first_drop
);

  localparam int PTR_W = $clog2(DEPTH);
  localparam int CNT_W = $clog2(DEPTH + 1);
  localparam int CMP_W = (CNT_W > rfdc_pkg::IDX_W) ? CNT_W : rfdc_pkg::IDX_W;
  localparam logic [PTR_W:0]   SUM_DEPTH = (PTR_W + 1)'(DEPTH);
  localparam logic [PTR_W-1:0] PTR_LAST  = PTR_W'(DEPTH - 1);
  localparam logic [CNT_W-1:0] CNT_FULL  = CNT_W'(DEPTH);

  // wrap base + off into the ring, both below DEPTH
  function automatic logic [PTR_W-1:0] slot_of(input logic [PTR_W-1:0] base,
                                               input logic [PTR_W-1:0] off);
    logic [PTR_W:0] sum;
    sum = {1'b0, base} + {1'b0, off};
    if (sum >= SUM_DEPTH) begin
      sum = sum - SUM_DEPTH;
    end
    return sum[PTR_W-1:0];
  endfunction

  logic [rfdc_pkg::ENTRY_W-1:0] mem [DEPTH];
  logic [rfdc_pkg::ENTRY_W-1:0] rdata;

  logic [rfdc_pkg::CMD_W-1:0]  lat_cmd;
  logic [rfdc_pkg::TYPE_W-1:0] lat_type;
  logic [rfdc_pkg::ID_W-1:0]   lat_id;
  logic [rfdc_pkg::IDX_W-1:0]  lat_idx;

  logic [PTR_W-1:0]           head;
  logic [CNT_W-1:0]           count;
  logic [CNT_W-1:0]           scan;
  logic [rfdc_pkg::DROP_W-1:0] drop;

  logic [CNT_W-1:0] scan_inc;
  logic [PTR_W-1:0] rd_off;
  logic [PTR_W-1:0] raddr;
  logic [PTR_W-1:0] waddr;
  logic [PTR_W-1:0] head_inc;
  logic             full;
  logic             empty;
  logic             id_inv;
  logic             peek_ok;
  logic             we;

  assign scan_inc = CNT_W'(scan + 1'b1);
  assign full     = (count == CNT_FULL);
  assign empty    = (count == '0);
  assign id_inv   = (lat_id == invalid_id);
  assign peek_ok  = (CMP_W'(lat_idx) < CMP_W'(count));
  assign head_inc = (head == PTR_LAST) ? '0 : PTR_W'(head + 1'b1);
  assign waddr    = slot_of(head, PTR_W'(count));
  assign raddr    = slot_of(head, rd_off);
  assign we       = (cmd.op == rfdc_pkg::OP_PUSH) && !id_inv && !full;

  always_comb begin
    case (cmd.rd_sel)
      rfdc_pkg::RD_HEAD: rd_off = '0;
      rfdc_pkg::RD_IDX:  rd_off = PTR_W'(CMP_W'(entry_index));
      rfdc_pkg::RD_SCAN: rd_off = PTR_W'(scan_inc);
      default:           rd_off = '0;
    endcase
  end

  assign stat.cmd        = lat_cmd;
  assign stat.id_invalid = id_inv;
  assign stat.empty      = empty;
  assign stat.hit        = (rdata == {lat_type, lat_id});
  assign stat.last       = (scan_inc >= count);

  assign pending_count = rfdc_pkg::PEND_W'(count);
  assign dropped_total = drop;

  // entry memory, one write and one registered read port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= {lat_type, lat_id};
    end
    rdata <= mem[raddr];
  end

  always_ff @(posedge clk) begin
    if (cmd.latch) begin
      lat_cmd  <= command;
      lat_type <= req_type;
      lat_id   <= asset_id;
      lat_idx  <= entry_index;
      scan     <= '0;
    end else if (cmd.op == rfdc_pkg::OP_SCAN_ADV) begin
      scan <= scan_inc;
    end
  end

  // queue pointers, drop counter, result strobe
  always_ff @(posedge clk) begin
    if (rst) begin
      head  <= '0;
      count <= '0;
      drop  <= '0;
      done  <= 1'b0;
    end else begin
      done <= 1'b0;
      case (cmd.op)
        rfdc_pkg::OP_PUSH: begin
          done <= 1'b1;
          if (!id_inv && !full) begin
            count <= CNT_W'(count + 1'b1);
          end else if (!id_inv && drop != rfdc_pkg::DROP_MAX) begin
            drop <= drop + 1'b1;
          end
        end
        rfdc_pkg::OP_POP: begin
          done <= 1'b1;
          if (!empty) begin
            head  <= head_inc;
            count <= CNT_W'(count - 1'b1);
          end
        end
        rfdc_pkg::OP_CLEAR: begin
          done  <= 1'b1;
          head  <= '0;
          count <= '0;
          drop  <= '0;
        end
        rfdc_pkg::OP_PEEK, rfdc_pkg::OP_REJECT, rfdc_pkg::OP_CHECK_END: begin
          done <= 1'b1;
        end
        default: ;
      endcase
    end
  end

  // result word
  always_ff @(posedge clk) begin
    case (cmd.op)
      rfdc_pkg::OP_PUSH: begin
        ok         <= !id_inv && !full;
        out_type   <= '0;
        out_id     <= '0;
        first_drop <= !id_inv && full && (drop == '0);
      end
      rfdc_pkg::OP_POP: begin
        ok         <= !empty;
        out_type   <= empty ? '0 : rdata[rfdc_pkg::ENTRY_W-1 -: rfdc_pkg::TYPE_W];
        out_id     <= empty ? '0 : rdata[rfdc_pkg::ID_W-1:0];
        first_drop <= 1'b0;
      end
      rfdc_pkg::OP_PEEK: begin
        ok         <= peek_ok;
        out_type   <= peek_ok ? rdata[rfdc_pkg::ENTRY_W-1 -: rfdc_pkg::TYPE_W] : '0;
        out_id     <= peek_ok ? rdata[rfdc_pkg::ID_W-1:0] : '0;
        first_drop <= 1'b0;
      end
      rfdc_pkg::OP_CLEAR: begin
        ok         <= 1'b1;
        out_type   <= '0;
        out_id     <= '0;
        first_drop <= 1'b0;
      end
      rfdc_pkg::OP_REJECT: begin
        ok         <= 1'b0;
        out_type   <= '0;
        out_id     <= '0;
        first_drop <= 1'b0;
      end
      rfdc_pkg::OP_CHECK_END: begin
        ok         <= cmd.check_ok;
        out_type   <= '0;
        out_id     <= '0;
        first_drop <= 1'b0;
      end
      default: ;
    endcase
  end

endmodule

>>> rtl/core/rfdc_chk.sv
`include "assert_macros.svh"

module rfdc_chk (
  input logic                        clk,
  input logic                        rst,
  input logic                        start,
  input logic                        busy,
  input logic                        done,
  input logic                        ok,
  input logic [rfdc_pkg::TYPE_W-1:0] out_type,
  input logic [rfdc_pkg::ID_W-1:0]   out_id,
  input logic [rfdc_pkg::DROP_W-1:0] dropped_total,
  input logic                        first_drop
);

  // a result only follows a command in flight
  `ASSERT_IMPLIES(a_done_after_busy, clk, rst, done, $past(busy), "result without a command")

  // the result strobe comes with the block ready again
  `ASSERT_IMPLIES(a_done_idle, clk, rst, done, !busy, "busy during result strobe")

  `ASSERT_NEXT(a_start_busy, clk, rst, start && !busy, busy, "accepted command not busy")

  // failed operations carry an empty entry
  `ASSERT_IMPLIES(a_fail_zero, clk, rst, done && !ok, out_type == '0 && out_id == '0, "payload on fail")

  `ASSERT_IMPLIES(a_first_drop, clk, rst, done && first_drop, !ok && dropped_total == 32'd1, "bad first drop")

endmodule

bind request_fifo_with_drop_count_core rfdc_chk u_rfdc_chk (
  .clk           (clk),
  .rst           (rst),
  .start         (start),
  .busy          (busy),
  .done          (done),
  .ok            (ok),
  .out_type      (out_type),
  .out_id        (out_id),
  .dropped_total (dropped_total),
  .first_drop    (first_drop)
);
